### src/nbbpc_pkg.sv
// ----------------------------------------------------------------------------
// NAND bad-block page chunker package
// Shared sizes, field constants, the command codes and the controller state
// type used by the chunker and its scan unit.
// ----------------------------------------------------------------------------
package nbbpc_pkg;

  // Geometry of the device and of the bad-block list.
  localparam int PAGE_BYTES     = 2048;
  localparam int BAD_LIST_DEPTH = 16;
  localparam int BLOCK_COUNT    = 512;

  // Fixed field widths of the item and result beats.
  localparam int ADDR_W    = 26;
  localparam int SIZE_W    = 27;
  localparam int ROW_W     = 15;
  localparam int COL_OUT_W = 11;
  localparam int LEN_OUT_W = 12;

  // Row layout: block number in the upper bits, page number below.
  localparam int PAGE_SHIFT = 6;
  localparam int BLK_W      = ROW_W - PAGE_SHIFT;
  localparam logic [ROW_W-1:0] BLOCK_FIELD = 15'h7FC0;
  localparam logic [ROW_W-1:0] ONE_BLOCK   = 15'h0040;

  // Widths that follow from the geometry.
  localparam int COL_W  = $clog2(PAGE_BYTES);
  localparam int ROOM_W = $clog2(PAGE_BYTES + 1);
  localparam int IDX_W  = (BAD_LIST_DEPTH > 1) ? $clog2(BAD_LIST_DEPTH) : 1;
  localparam int CNT_W  = $clog2(BAD_LIST_DEPTH + 1);
  localparam int SCAN_W = $clog2(BLOCK_COUNT + 1);

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_SPARE = 2'd1,
    MODE_START = 2'd2,
    MODE_CHUNK = 2'd3
  } nbbpc_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_EMIT
  } nbbpc_state_e;

  // Write request from the scan unit into the bad-block list.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [BLK_W-1:0] blk;
  } nbbpc_append_t;

endpackage

### src/nbbpc_if.sv
// ----------------------------------------------------------------------------
// NAND bad-block page chunker channels
// Valid/ready channels for command beats and for chunk beats.
// ----------------------------------------------------------------------------
interface nbbpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [7:0]                  spare_byte;
  logic                        last_spare;
  logic [nbbpc_pkg::ADDR_W-1:0] start_address;
  logic [nbbpc_pkg::SIZE_W-1:0] transfer_size;

  modport source (
    output valid, mode, spare_byte, last_spare, start_address, transfer_size,
    input  ready
  );
  modport sink (
    input  valid, mode, spare_byte, last_spare, start_address, transfer_size,
    output ready
  );
endinterface

interface nbbpc_out_if;
  logic                           valid;
  logic                           ready;
  logic [nbbpc_pkg::ROW_W-1:0]     chunk_row;
  logic [nbbpc_pkg::COL_OUT_W-1:0] chunk_col;
  logic [nbbpc_pkg::LEN_OUT_W-1:0] chunk_length;
  logic                           last_chunk;

  modport source (
    output valid, chunk_row, chunk_col, chunk_length, last_chunk,
    input  ready
  );
  modport sink (
    input  valid, chunk_row, chunk_col, chunk_length, last_chunk,
    output ready
  );
endinterface

### src/nand_bad_block_page_chunker.sv
// ----------------------------------------------------------------------------
// NAND bad-block page chunker
// Builds a bad-block list from spare-area bytes and cuts flash transfers
// into page chunks whose rows step over the listed blocks.
// ----------------------------------------------------------------------------
// Usage: every command arrives as one beat on in_i. Mode 0 clears the list
// and the scan position, mode 1 delivers one spare-area byte, mode 2 loads a
// start address and a byte count, and mode 3 asks for the next page chunk.
// Modes 0 to 2 are absorbed in the cycle of the handshake and produce no beat
// on out_o. A mode 3 beat with bytes still to send reads the bad-block list
// one entry per cycle from its memory, which has separate write and read ports,
// comparing the cursor row against each entry in list order and moving to
// the next block on a hit. The chunk beat is then registered on out_o, and
// in_i.ready stays low from the handshake until the beat is loaded, so the
// block takes no new command beat before it is through with the chunk.
// A mode 3 beat with nothing left leaves the block idle at once.
// If the receiver stalls, the chunk waits in the output register while the
// block keeps taking list, scan and start beats; a further chunk request
// waits in its final step until the output register is free.
// Reset clears the scan position, the list count and the transfer cursor.
// The list memory itself is not cleared: only entries below the count are
// ever compared, and those have always been written.
// ----------------------------------------------------------------------------
module nand_bad_block_page_chunker (
  input  logic        clk_i,
  input  logic        rst_ni,
  nbbpc_in_if.sink    in_i,
  nbbpc_out_if.source out_o
);

  nbbpc_pkg::nbbpc_state_e state_q, state_d;

  logic                              in_acc;
  logic                              is_clear, is_spare, is_start, is_chunk;
  logic                              chunk_go;
  logic                              last_entry;
  logic                              hit;
  logic                              load_out;

  nbbpc_pkg::nbbpc_append_t          append;
  logic [nbbpc_pkg::CNT_W-1:0]       bad_count;

  // Transfer cursor.
  logic [nbbpc_pkg::ROW_W-1:0]       row_q;
  logic [nbbpc_pkg::COL_W-1:0]       col_q;
  logic [nbbpc_pkg::SIZE_W-1:0]      left_q;

  // Chunk under construction.
  logic [nbbpc_pkg::COL_W-1:0]       chunk_col_q;
  logic [nbbpc_pkg::ROOM_W-1:0]      chunk_len_q;
  logic                              chunk_last_q;
  logic [nbbpc_pkg::ROOM_W-1:0]      room;
  logic                              fits;
  logic [nbbpc_pkg::ROOM_W-1:0]      chunk_len;

  // List walk.
  logic [nbbpc_pkg::IDX_W-1:0]       idx_q;
  logic [nbbpc_pkg::IDX_W-1:0]       rd_addr;
  logic [nbbpc_pkg::BLK_W-1:0]       rdata_q;
  logic [nbbpc_pkg::BLK_W-1:0]       list_mem [nbbpc_pkg::BAD_LIST_DEPTH];

  // Output register.
  logic                              out_valid_q;
  logic [nbbpc_pkg::ROW_W-1:0]       out_row_q;
  logic [nbbpc_pkg::COL_OUT_W-1:0]   out_col_q;
  logic [nbbpc_pkg::LEN_OUT_W-1:0]   out_len_q;
  logic                              out_last_q;

  assign in_acc = in_i.valid && in_i.ready;

  always_comb begin
    is_clear = 1'b0;
    is_spare = 1'b0;
    is_start = 1'b0;
    is_chunk = 1'b0;
    case (nbbpc_pkg::nbbpc_mode_e'(in_i.mode))
      nbbpc_pkg::MODE_CLEAR: is_clear = 1'b1;
      nbbpc_pkg::MODE_SPARE: is_spare = 1'b1;
      nbbpc_pkg::MODE_START: is_start = 1'b1;
      nbbpc_pkg::MODE_CHUNK: is_chunk = 1'b1;
      default:               is_clear = 1'b0;
    endcase
  end

  // A chunk request only starts work while bytes remain.
  assign chunk_go = in_acc && is_chunk && (left_q != '0);

  nbbpc_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (in_acc && is_clear),
    .byte_i       (in_acc && is_spare),
    .spare_byte_i (in_i.spare_byte),
    .last_spare_i (in_i.last_spare),
    .append_o     (append),
    .bad_count_o  (bad_count)
  );

  // The chunk runs to the end of the page or to the end of the transfer.
  assign room      = nbbpc_pkg::ROOM_W'(nbbpc_pkg::PAGE_BYTES) -
                     nbbpc_pkg::ROOM_W'(col_q);
  assign fits      = left_q <= nbbpc_pkg::SIZE_W'(room);
  assign chunk_len = fits ? nbbpc_pkg::ROOM_W'(left_q) : room;

  assign last_entry = (nbbpc_pkg::CNT_W'(idx_q) + 1'b1) == bad_count;
  assign hit        = rdata_q == row_q[nbbpc_pkg::ROW_W-1:nbbpc_pkg::PAGE_SHIFT];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      nbbpc_pkg::ST_IDLE: begin
        if (chunk_go) begin
          state_d = (bad_count == '0) ? nbbpc_pkg::ST_EMIT : nbbpc_pkg::ST_SKIP;
        end
      end
      nbbpc_pkg::ST_SKIP: begin
        if (last_entry) begin
          state_d = nbbpc_pkg::ST_EMIT;
        end
      end
      nbbpc_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = nbbpc_pkg::ST_IDLE;
        end
      end
      default: state_d = nbbpc_pkg::ST_IDLE;
    endcase
  end

  // State outputs: the list address runs one entry ahead of the compare.
  always_comb begin
    in_i.ready = 1'b0;
    rd_addr    = '0;
    load_out   = 1'b0;
    case (state_q)
      nbbpc_pkg::ST_IDLE: in_i.ready = 1'b1;
      nbbpc_pkg::ST_SKIP: rd_addr = idx_q + 1'b1;
      nbbpc_pkg::ST_EMIT: load_out = !out_valid_q || out_o.ready;
      default:            in_i.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nbbpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Bad-block list memory: appends and walk reads never meet, since the
  // walk only runs while no command beat is taken.
  always_ff @(posedge clk_i) begin
    if (append.we) begin
      list_mem[append.addr] <= append.blk;
    end
    rdata_q <= list_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      left_q <= '0;
    end else begin
      if (in_acc && is_start) begin
        row_q  <= nbbpc_pkg::ROW_W'(in_i.start_address >> nbbpc_pkg::COL_W);
        col_q  <= in_i.start_address[nbbpc_pkg::COL_W-1:0];
        left_q <= in_i.transfer_size;
      end else if (chunk_go) begin
        col_q  <= '0;
        left_q <= left_q - nbbpc_pkg::SIZE_W'(chunk_len);
      end else if (state_q == nbbpc_pkg::ST_SKIP && hit) begin
        // Listed block: jump to page 0 of the next one; later entries see
        // the moved row.
        row_q <= (row_q & nbbpc_pkg::BLOCK_FIELD) + nbbpc_pkg::ONE_BLOCK;
      end else if (load_out) begin
        row_q <= row_q + 1'b1;
      end
    end
  end

  // Chunk capture and the list index need no reset.
  always_ff @(posedge clk_i) begin
    if (chunk_go) begin
      chunk_col_q  <= col_q;
      chunk_len_q  <= chunk_len;
      chunk_last_q <= fits;
      idx_q        <= '0;
    end else if (state_q == nbbpc_pkg::ST_SKIP) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_row_q  <= row_q;
      out_col_q  <= nbbpc_pkg::COL_OUT_W'(chunk_col_q);
      out_len_q  <= nbbpc_pkg::LEN_OUT_W'(chunk_len_q);
      out_last_q <= chunk_last_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.chunk_row    = out_row_q;
  assign out_o.chunk_col    = out_col_q;
  assign out_o.chunk_length = out_len_q;
  assign out_o.last_chunk   = out_last_q;

endmodule

### src/nbbpc_scan.sv
// ----------------------------------------------------------------------------
// NAND bad-block spare-area scanner
// Tracks the block under scan and raises a list append for each bad block while the list has room.
// ----------------------------------------------------------------------------
module nbbpc_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           byte_i,
  input  logic [7:0]                     spare_byte_i,
  input  logic                           last_spare_i,
  output nbbpc_pkg::nbbpc_append_t       append_o,
  output logic [nbbpc_pkg::CNT_W-1:0]    bad_count_o
);

  logic [nbbpc_pkg::SCAN_W-1:0] scan_block_q, scan_block_d;
  logic [nbbpc_pkg::CNT_W-1:0]  count_q, count_d;
  logic                         zero_q, zero_d;
  logic                         active;
  logic                         zero_now;
  logic                         list_room;

  assign active    = scan_block_q < nbbpc_pkg::SCAN_W'(nbbpc_pkg::BLOCK_COUNT);
  assign zero_now  = zero_q || (spare_byte_i == 8'd0);
  assign list_room = count_q < nbbpc_pkg::CNT_W'(nbbpc_pkg::BAD_LIST_DEPTH);

  always_comb begin
    scan_block_d  = scan_block_q;
    count_d       = count_q;
    zero_d        = zero_q;
    append_o.we   = 1'b0;
    append_o.addr = count_q[nbbpc_pkg::IDX_W-1:0];
    append_o.blk  = nbbpc_pkg::BLK_W'(scan_block_q);
    if (clear_i) begin
      scan_block_d = '0;
      count_d      = '0;
      zero_d       = 1'b0;
    end else if (byte_i && active) begin
      if (last_spare_i) begin
        // Block finished: record it if any of its bytes was zero and the list has room.
        if (zero_now && list_room) begin
          append_o.we = 1'b1;
          count_d     = count_q + 1'b1;
        end
        scan_block_d = scan_block_q + 1'b1;
        zero_d       = 1'b0;
      end else begin
        zero_d = zero_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_block_q <= '0;
      count_q      <= '0;
      zero_q       <= 1'b0;
    end else begin
      scan_block_q <= scan_block_d;
      count_q      <= count_d;
      zero_q       <= zero_d;
    end
  end

  assign bad_count_o = count_q;

endmodule

### src/nbbpc_checker.sv
// ----------------------------------------------------------------------------
// NAND bad-block page chunker port checker
// Watches the chunker's ports for handshake and chunk-shape slips.
// ----------------------------------------------------------------------------
module nbbpc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [nbbpc_pkg::ROW_W-1:0]     chunk_row_i,
  input logic [nbbpc_pkg::COL_OUT_W-1:0] chunk_col_i,
  input logic [nbbpc_pkg::LEN_OUT_W-1:0] chunk_length_i,
  input logic                           last_chunk_i
);

  logic [nbbpc_pkg::ROOM_W:0] chunk_end;

  assign chunk_end = (nbbpc_pkg::ROOM_W + 1)'(chunk_col_i) +
                     (nbbpc_pkg::ROOM_W + 1)'(chunk_length_i);

  // A stalled chunk beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(chunk_row_i) &&
      $stable(chunk_col_i) && $stable(chunk_length_i) &&
      $stable(last_chunk_i))
    else $error("chunk beat changed while stalled");

  // Every chunk is non-empty and stays inside its page.
  a_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> chunk_length_i != '0 &&
      chunk_end <= (nbbpc_pkg::ROOM_W + 1)'(nbbpc_pkg::PAGE_BYTES))
    else $error("chunk leaves its page");

  // A chunk that does not end the transfer fills its page to the end.
  a_full_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_chunk_i |->
      chunk_end == (nbbpc_pkg::ROOM_W + 1)'(nbbpc_pkg::PAGE_BYTES))
    else $error("intermediate chunk short of page end");

  // A new chunk appears only after commands were held off.
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("chunk produced while commands were being taken");

endmodule

bind nand_bad_block_page_chunker nbbpc_checker u_nbbpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .chunk_row_i    (out_o.chunk_row),
  .chunk_col_i    (out_o.chunk_col),
  .chunk_length_i (out_o.chunk_length),
  .last_chunk_i   (out_o.last_chunk)
);
